[rtl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg: shared types, constants and helpers of the URL percent decoder
// Character codes, the group type that links the front and back parts, and
// the hex digit helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CASE_MASK  = 8'hDF;

  // Group queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Up to three output bytes caused by one input request
  typedef struct packed {
    logic [2:0][7:0] bytes;  // bytes[0] leaves first
    logic [1:0]      cnt;    // number of bytes, 1 to 3
    logic            last;   // group closes the buffer
    logic            chg;    // buffer saw a decode (valid when last)
  } upd_grp_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } upd_qstat_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Value of a hex digit, either case
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] u;
    u = (c & CASE_MASK) - 8'h37;
    if (c >= 8'h41) hex_val = u[3:0];
    else            hex_val = c[3:0];
  endfunction

endpackage

[rtl/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes %HH escapes and '+' per buffer, passes broken escapes literally and
// flags on the final byte whether anything was decoded.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------
//  input   | push / full       | in_byte[7:0], in_last
//  result  | empty / pop       | out_byte[7:0], out_last, out_any_change
//
//  One input request is taken per cycle while the group queue has room.
//  A request yields zero to three output bytes; the back part hands out one
//  byte per cycle, so the byte rate of the result side sets the throughput.
//  Requests that yield no byte (pending escape) take no slot.
//  Synchronous active-low reset empties the queue and clears escape state.
//  full rises after four groups wait in the queue.
// ----------------------------------------------------------------------------
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_any_change
);
  import upd_pkg::*;

  logic       acc;
  logic       grp_vld;
  upd_grp_t   grp;
  upd_grp_t   head;
  upd_qstat_t stat;
  logic       deq;

  assign acc  = push && !stat.full;
  assign full = stat.full;

  // Front: escape tracking
  upd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_byte),
    .in_last (in_last),
    .grp_vld (grp_vld),
    .grp     (grp)
  );

  // Group queue
  upd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (grp_vld),
    .wr_grp (grp),
    .rd     (deq),
    .head   (head),
    .stat   (stat)
  );

  // Back: byte sequencer
  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_any_change (out_any_change),
    .deq            (deq)
  );

endmodule

[rtl/upd_front.sv]
// ----------------------------------------------------------------------------
// upd_front: escape tracking and grouping
// Runs the escape state per input request and builds the group of output
// bytes it causes; empty groups are dropped here.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              grp_vld,
  output upd_pkg::upd_grp_t grp
);
  import upd_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       changed_r, changed_nxt;

  logic [2:0][7:0] bytes;
  logic [1:0]      n;
  logic            chg;
  logic            do_plain;
  logic            hex;

  // Next state and the bytes of this request
  always_comb begin
    hex      = is_hex(in_byte);
    bytes    = '0;
    n        = 2'd0;
    chg      = 1'b0;
    do_plain = 1'b0;
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_PCT: begin
        if (hex) begin
          phase_nxt = PH_DIGIT;
          held_nxt  = in_byte;
        end else begin
          bytes[0] = CH_PERCENT;
          n        = 2'd1;
          do_plain = 1'b1;
        end
      end
      PH_DIGIT: begin
        held_nxt = 8'h00;
        if (hex) begin
          bytes[0] = {hex_val(held_r), hex_val(in_byte)};
          n        = 2'd1;
          chg      = 1'b1;
        end else begin
          bytes[0] = CH_PERCENT;
          bytes[1] = held_r;
          n        = 2'd2;
          do_plain = 1'b1;
        end
      end
      PH_IDLE: do_plain = 1'b1;
      default: do_plain = 1'b1;
    endcase

    // Byte handled with no escape pending
    if (do_plain) begin
      if (in_byte == CH_PERCENT) begin
        phase_nxt = PH_PCT;
      end else if (in_byte == CH_PLUS) begin
        bytes[n] = CH_SPACE;
        n        = n + 2'd1;
        chg      = 1'b1;
      end else begin
        bytes[n] = in_byte;
        n        = n + 2'd1;
      end
    end

    // Buffer end: release a pending escape literally
    changed_nxt = changed_r | chg;
    if (in_last) begin
      if (phase_nxt == PH_PCT) begin
        bytes[n] = CH_PERCENT;
        n        = n + 2'd1;
      end else if (phase_nxt == PH_DIGIT) begin
        bytes[n]         = CH_PERCENT;
        bytes[n + 2'd1]  = held_nxt;
        n                = n + 2'd2;
      end
      phase_nxt   = PH_IDLE;
      held_nxt    = 8'h00;
    end
  end

  assign grp_vld   = acc && (n != 2'd0);
  assign grp.bytes = bytes;
  assign grp.cnt   = n;
  assign grp.last  = in_last;
  assign grp.chg   = in_last & changed_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      held_r    <= 8'h00;
      changed_r <= 1'b0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      changed_r <= in_last ? 1'b0 : changed_nxt;
    end
  end

endmodule

[rtl/upd_queue.sv]
// ----------------------------------------------------------------------------
// upd_queue: group queue between front and back
// Small register queue of output groups; the head entry is read in place.
// ----------------------------------------------------------------------------
module upd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  upd_pkg::upd_grp_t  wr_grp,
  input  logic               rd,
  output upd_pkg::upd_grp_t  head,
  output upd_pkg::upd_qstat_t stat
);
  import upd_pkg::*;

  upd_grp_t          q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign head       = q_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr) q_r[wr_ptr_r] <= wr_grp;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (rd) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + (QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/upd_back.sv]
// ----------------------------------------------------------------------------
// upd_back: output sequencer
// Walks the bytes of the head group one per pop and retires the group
// after its final byte.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  upd_pkg::upd_grp_t   head,
  input  upd_pkg::upd_qstat_t stat,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_any_change,
  output logic                deq
);
  import upd_pkg::*;

  logic [1:0] idx_r;
  logic       at_end;
  logic       take;

  assign at_end         = (idx_r == head.cnt - 2'd1);
  assign empty          = stat.empty;
  assign take           = pop && !stat.empty;
  assign deq            = take && at_end;
  assign out_byte       = head.bytes[idx_r];
  assign out_last       = head.last && at_end;
  assign out_any_change = head.chg && at_end;

  // Byte index within the head group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (take) begin
      idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
